// ===== rtl/core/ata_seq_pkg.sv =====
// ata pio sector transfer sequencer: shared types, codes and helpers
// used by ata_seq_front, ata_seq_fifo, ata_seq_back and the top level
`default_nettype none

package ata_seq_pkg;

  localparam int WORDS_PER_SECTOR = 256;
  localparam int QUEUE_DEPTH      = 4;

  localparam int LBA_W  = 28;
  localparam int CNT_W  = 16;
  localparam int WORD_W = 8;
  localparam int TMO_W  = 27;
  localparam int DATA_W = 16;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 48;

  localparam logic [TMO_W-1:0] READY_TMO_RST = 27'd100000000;
  localparam logic [TMO_W-1:0] DRQ_TMO_RST   = 27'd10000000;

  // configuration register indexes
  localparam logic CFG_READY_TMO = 1'b0;
  localparam logic CFG_DRQ_TMO   = 1'b1;

  // task-file offsets
  localparam logic [2:0] REG_DATA    = 3'd0;
  localparam logic [2:0] REG_COUNT   = 3'd2;
  localparam logic [2:0] REG_LBA_LO  = 3'd3;
  localparam logic [2:0] REG_LBA_MID = 3'd4;
  localparam logic [2:0] REG_LBA_HI  = 3'd5;
  localparam logic [2:0] REG_DRIVE   = 3'd6;
  localparam logic [2:0] REG_CMD     = 3'd7;

  // status bits and command codes
  localparam logic [7:0] ST_FLOAT  = 8'hFF;
  localparam logic [7:0] ST_BSY    = 8'h80;
  localparam logic [7:0] ST_DRDY   = 8'h40;
  localparam logic [7:0] ST_DF     = 8'h20;
  localparam logic [7:0] ST_DRQ    = 8'h08;
  localparam logic [7:0] ST_ERR    = 8'h01;
  localparam logic [7:0] CMD_READ  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] DRIVE_LBA = 8'hE0;
  localparam logic [3:0] LBA_TOP_MASK = 4'hF;

  localparam logic [2:0] BURST_LAST = 3'd7;

  typedef enum logic [1:0] {
    OP_START_RD = 2'd0,
    OP_START_WR = 2'd1,
    OP_STATUS   = 2'd2,
    OP_DATA     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_WAIT_CMD = 3'd1,
    PH_WAIT_DRQ = 3'd2,
    PH_XFER     = 3'd3,
    PH_WAIT_END = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ACT_REG_WR   = 3'd0,
    ACT_DELAY    = 3'd1,
    ACT_TO_DRIVE = 3'd2,
    ACT_TO_BUF   = 3'd3,
    ACT_DONE     = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    CLS_WAIT = 2'd0,
    CLS_MET  = 2'd1,
    CLS_FAIL = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    JOB_DONE  = 2'd0,
    JOB_BURST = 2'd1,
    JOB_DATA  = 2'd2
  } job_kind_t;

  // one queued job: a done report, a command burst or a data move
  typedef struct packed {
    job_kind_t          kind;
    logic               ok;
    logic               is_write;
    logic [LBA_W-1:0]   lba;
    logic [CNT_W-1:0]   sec_idx;
    logic [WORD_W-1:0]  word_idx;
    logic [DATA_W-1:0]  data;
  } job_t;

  typedef struct packed {
    act_t               action;
    logic [2:0]         reg_idx;
    logic [DATA_W-1:0]  value;
    logic [CNT_W-1:0]   sec_idx;
    logic [WORD_W-1:0]  word_idx;
    logic               ok;
    logic               last;
  } out_item_t;

  function automatic cls_t classify(input logic [7:0] st, input logic want_drq);
    cls_t c;
    if (st == ST_FLOAT) begin
      c = CLS_FAIL;
    end else if ((st & ST_BSY) != 8'h00) begin
      c = CLS_WAIT;
    end else if ((st & (ST_ERR | ST_DF)) != 8'h00) begin
      c = CLS_FAIL;
    end else if (want_drq) begin
      c = ((st & ST_DRQ) != 8'h00) ? CLS_MET : CLS_WAIT;
    end else if ((st & ST_DRQ) != 8'h00) begin
      c = CLS_WAIT;
    end else if ((st & ST_DRDY) == 8'h00) begin
      c = CLS_WAIT;
    end else begin
      c = CLS_MET;
    end
    return c;
  endfunction

  function automatic logic [TMO_W-1:0] load_polls(input logic [TMO_W-1:0] r);
    return (r == '0) ? TMO_W'(1) : r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ata_seq_front.sv =====
// front part: classifies input items, keeps the run state and timeouts,
// pushes jobs to the queue; depends on ata_seq_pkg
`default_nettype none

module ata_seq_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          acc,
  input  wire ata_seq_pkg::op_t              opcode,
  input  wire logic [ata_seq_pkg::LBA_W-1:0] start_lba,
  input  wire logic [ata_seq_pkg::CNT_W-1:0] sector_count,
  input  wire logic [7:0]                    status_byte,
  input  wire logic [ata_seq_pkg::DATA_W-1:0] data_word,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [ata_seq_pkg::TMO_W-1:0] cfg_wdata,
  output ata_seq_pkg::job_t                  push_job,
  output logic                               push
);

  ata_seq_pkg::phase_t                 phase_r, phase_nxt;
  logic                                is_write_r, is_write_nxt;
  logic [ata_seq_pkg::LBA_W-1:0]       lba_r, lba_nxt;
  logic [ata_seq_pkg::CNT_W-1:0]       left_r, left_nxt;
  logic [ata_seq_pkg::CNT_W-1:0]       done_r, done_nxt;
  logic [ata_seq_pkg::WORD_W-1:0]      word_r, word_nxt;
  logic [ata_seq_pkg::TMO_W-1:0]       polls_r, polls_nxt;
  logic [ata_seq_pkg::TMO_W-1:0]       rdy_tmo_r, drq_tmo_r;
  ata_seq_pkg::cls_t                   cls;
  logic                                is_idle, is_wait;
  logic [ata_seq_pkg::TMO_W-1:0]       polls_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= ata_seq_pkg::PH_IDLE;
      is_write_r <= 1'b0;
      lba_r      <= '0;
      left_r     <= '0;
      done_r     <= '0;
      word_r     <= '0;
      polls_r    <= '0;
      rdy_tmo_r  <= ata_seq_pkg::READY_TMO_RST;
      drq_tmo_r  <= ata_seq_pkg::DRQ_TMO_RST;
    end else begin
      phase_r    <= phase_nxt;
      is_write_r <= is_write_nxt;
      lba_r      <= lba_nxt;
      left_r     <= left_nxt;
      done_r     <= done_nxt;
      word_r     <= word_nxt;
      polls_r    <= polls_nxt;
      if (cfg_we) begin
        if (cfg_index == ata_seq_pkg::CFG_READY_TMO) begin
          rdy_tmo_r <= cfg_wdata;
        end else begin
          drq_tmo_r <= cfg_wdata;
        end
      end
    end
  end

  always_comb begin
    is_idle = 1'b0;
    is_wait = 1'b0;
    case (phase_r)
      ata_seq_pkg::PH_WAIT_CMD,
      ata_seq_pkg::PH_WAIT_DRQ,
      ata_seq_pkg::PH_WAIT_END: is_wait = 1'b1;
      ata_seq_pkg::PH_XFER:     is_idle = 1'b0;
      default:                  is_idle = 1'b1;
    endcase
  end

  assign cls       = ata_seq_pkg::classify(status_byte, phase_r == ata_seq_pkg::PH_WAIT_DRQ);
  assign polls_dec = polls_r - ata_seq_pkg::TMO_W'(1);

  always_comb begin
    phase_nxt    = phase_r;
    is_write_nxt = is_write_r;
    lba_nxt      = lba_r;
    left_nxt     = left_r;
    done_nxt     = done_r;
    word_nxt     = word_r;
    polls_nxt    = polls_r;
    push         = 1'b0;
    push_job     = '0;
    push_job.sec_idx  = done_r;
    push_job.lba      = lba_r;
    push_job.is_write = is_write_r;

    if (acc) begin
      case (opcode)
        ata_seq_pkg::OP_START_RD,
        ata_seq_pkg::OP_START_WR: begin
          if (is_idle) begin
            is_write_nxt = (opcode == ata_seq_pkg::OP_START_WR);
            lba_nxt      = start_lba;
            left_nxt     = sector_count;
            done_nxt     = '0;
            word_nxt     = '0;
            phase_nxt    = (sector_count != '0) ? ata_seq_pkg::PH_WAIT_CMD
                                                : ata_seq_pkg::PH_WAIT_END;
            polls_nxt    = ata_seq_pkg::load_polls(rdy_tmo_r);
          end
        end
        ata_seq_pkg::OP_STATUS: begin
          if (is_wait) begin
            case (cls)
              ata_seq_pkg::CLS_WAIT: begin
                polls_nxt = polls_dec;
                if (polls_dec == '0) begin
                  push          = 1'b1;
                  push_job.kind = ata_seq_pkg::JOB_DONE;
                  phase_nxt     = ata_seq_pkg::PH_IDLE;
                end
              end
              ata_seq_pkg::CLS_MET: begin
                case (phase_r)
                  ata_seq_pkg::PH_WAIT_END: begin
                    push          = 1'b1;
                    push_job.kind = ata_seq_pkg::JOB_DONE;
                    push_job.ok   = 1'b1;
                    phase_nxt     = ata_seq_pkg::PH_IDLE;
                    polls_nxt     = '0;
                  end
                  ata_seq_pkg::PH_WAIT_DRQ: begin
                    phase_nxt = ata_seq_pkg::PH_XFER;
                    word_nxt  = '0;
                  end
                  default: begin
                    // drive ready before the command: issue the task-file burst
                    push          = 1'b1;
                    push_job.kind = ata_seq_pkg::JOB_BURST;
                    phase_nxt     = ata_seq_pkg::PH_WAIT_DRQ;
                    polls_nxt     = ata_seq_pkg::load_polls(drq_tmo_r);
                  end
                endcase
              end
              default: begin
                push          = 1'b1;
                push_job.kind = ata_seq_pkg::JOB_DONE;
                phase_nxt     = ata_seq_pkg::PH_IDLE;
                polls_nxt     = '0;
              end
            endcase
          end
        end
        default: begin
          if (phase_r == ata_seq_pkg::PH_XFER) begin
            push              = 1'b1;
            push_job.kind     = ata_seq_pkg::JOB_DATA;
            push_job.word_idx = word_r;
            push_job.data     = data_word;
            if (word_r == ata_seq_pkg::WORD_W'(ata_seq_pkg::WORDS_PER_SECTOR - 1)) begin
              word_nxt  = '0;
              lba_nxt   = lba_r + ata_seq_pkg::LBA_W'(1);
              left_nxt  = left_r - ata_seq_pkg::CNT_W'(1);
              done_nxt  = done_r + ata_seq_pkg::CNT_W'(1);
              phase_nxt = (left_r != ata_seq_pkg::CNT_W'(1)) ? ata_seq_pkg::PH_WAIT_CMD
                                                             : ata_seq_pkg::PH_WAIT_END;
              polls_nxt = ata_seq_pkg::load_polls(rdy_tmo_r);
            end else begin
              word_nxt = word_r + ata_seq_pkg::WORD_W'(1);
            end
          end
        end
      endcase
    end
  end

  // idle always leaves the poll counter cleared
  a_idle_polls: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ata_seq_pkg::PH_IDLE |-> polls_r == '0)
    else $error("poll counter not cleared while idle");

  // a wait phase always has at least one sample left
  a_wait_polls: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ata_seq_pkg::PH_WAIT_CMD || phase_r == ata_seq_pkg::PH_WAIT_DRQ ||
     phase_r == ata_seq_pkg::PH_WAIT_END) |-> polls_r != '0)
    else $error("wait phase with no samples left");

endmodule

`default_nettype wire

// ===== rtl/core/ata_seq_fifo.sv =====
// short job queue between the front and back parts
// depends on ata_seq_pkg for the job type
`default_nettype none

module ata_seq_fifo #(
  parameter int DEPTH = ata_seq_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ata_seq_pkg::job_t push_job,
  input  wire logic              pop,
  output ata_seq_pkg::job_t      head,
  output logic                   empty,
  output logic                   full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ata_seq_pkg::job_t  mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job queue underflow");

endmodule

`default_nettype wire

// ===== rtl/core/ata_seq_back.sv =====
// back part: expands queued jobs into result items and holds the
// output register; depends on ata_seq_pkg
`default_nettype none

module ata_seq_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ata_seq_pkg::job_t head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ata_seq_pkg::out_item_t out_item
);

  logic [2:0]             beat_r, beat_nxt;
  logic                   valid_r, valid_nxt;
  ata_seq_pkg::out_item_t item_r, item_nxt;
  ata_seq_pkg::out_item_t beat_item;
  logic                   beat_last;
  logic                   load;

  assign out_valid = valid_r;
  assign out_item  = item_r;
  assign load      = !valid_r || out_ready;

  // result item for the current beat of the head job
  always_comb begin
    beat_item         = '0;
    beat_item.sec_idx = head.sec_idx;
    beat_last         = 1'b1;
    case (head.kind)
      ata_seq_pkg::JOB_BURST: begin
        beat_last        = (beat_r == ata_seq_pkg::BURST_LAST);
        beat_item.last   = beat_last;
        beat_item.action = ata_seq_pkg::ACT_REG_WR;
        case (beat_r)
          3'd0: begin
            beat_item.reg_idx = ata_seq_pkg::REG_DRIVE;
            beat_item.value   = {8'h00, ata_seq_pkg::DRIVE_LBA |
                                 {4'h0, head.lba[27:24] & ata_seq_pkg::LBA_TOP_MASK}};
          end
          3'd2: begin
            beat_item.reg_idx = ata_seq_pkg::REG_COUNT;
            beat_item.value   = 16'd1;
          end
          3'd3: begin
            beat_item.reg_idx = ata_seq_pkg::REG_LBA_LO;
            beat_item.value   = {8'h00, head.lba[7:0]};
          end
          3'd4: begin
            beat_item.reg_idx = ata_seq_pkg::REG_LBA_MID;
            beat_item.value   = {8'h00, head.lba[15:8]};
          end
          3'd5: begin
            beat_item.reg_idx = ata_seq_pkg::REG_LBA_HI;
            beat_item.value   = {8'h00, head.lba[23:16]};
          end
          3'd6: begin
            beat_item.reg_idx = ata_seq_pkg::REG_CMD;
            beat_item.value   = {8'h00, head.is_write ? ata_seq_pkg::CMD_WRITE
                                                      : ata_seq_pkg::CMD_READ};
          end
          default: begin
            // beats one and seven are the settle markers
            beat_item.action = ata_seq_pkg::ACT_DELAY;
          end
        endcase
      end
      ata_seq_pkg::JOB_DATA: begin
        beat_item.action   = head.is_write ? ata_seq_pkg::ACT_TO_DRIVE
                                           : ata_seq_pkg::ACT_TO_BUF;
        beat_item.reg_idx  = ata_seq_pkg::REG_DATA;
        beat_item.value    = head.data;
        beat_item.word_idx = head.word_idx;
        beat_item.last     = 1'b1;
      end
      default: begin
        beat_item.action = ata_seq_pkg::ACT_DONE;
        beat_item.ok     = head.ok;
        beat_item.last   = 1'b1;
      end
    endcase
  end

  always_comb begin
    beat_nxt  = beat_r;
    valid_nxt = valid_r;
    item_nxt  = item_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = !empty;
      if (!empty) begin
        item_nxt = beat_item;
        if (beat_last) begin
          pop      = 1'b1;
          beat_nxt = '0;
        end else begin
          beat_nxt = beat_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      beat_r  <= beat_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  // a burst in progress keeps its job at the head of the queue
  a_beat_burst: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r != '0 |-> (!empty && head.kind == ata_seq_pkg::JOB_BURST))
    else $error("beat counter running without a burst job");

endmodule

`default_nettype wire

// ===== rtl/core/ata_pio_sector_transfer_sequencer.sv =====
// top level of the ata pio lba28 sector transfer sequencer
// depends on ata_seq_pkg, ata_seq_front, ata_seq_fifo and ata_seq_back
//
// channel  direction  handshake          contents
// in_      slave      tvalid / tready    tuser: opcode; tdata: lba, count, status, word
// out_     master     tvalid / tready    tuser: action; tdata: result fields; tlast
// cfg_     write      cfg_we             index 0 ready timeout, 1 drq timeout
//
// one input item per cycle while the job queue has room; a data word's result
// is presented after passing through the job queue and the output register, a
// ready status before a command makes a burst of eight results on the output
// the queue (QUEUE_DEPTH jobs) lets status samples keep coming during a burst
// reset is synchronous, active low; the output register decouples out_tready
// from in_tready, which only drops when the queue is full
`default_nettype none

module ata_pio_sector_transfer_sequencer #(
  parameter int QUEUE_DEPTH = ata_seq_pkg::QUEUE_DEPTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // tuser: opcode [1:0]
  // tdata: start_lba [27:0], sector_count [43:28], status_byte [51:44],
  //        data_word [67:52], zero [71:68]
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [ata_seq_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic [1:0]                           in_tuser,
  // tuser: action [2:0]
  // tdata: register_index [2:0], value [18:3], sector_index [34:19],
  //        word_index [42:35], ok [43], zero [47:44]
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [ata_seq_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic [2:0]                                out_tuser,
  output logic                                      out_tlast,
  // configuration writes
  input  wire logic                                 cfg_we,
  input  wire logic                                 cfg_index,
  input  wire logic [ata_seq_pkg::TMO_W-1:0]        cfg_wdata
);

  ata_seq_pkg::job_t      push_job, head;
  ata_seq_pkg::out_item_t out_item;
  logic                   push, pop, empty, full, acc;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  // front: decode, run state, timeouts
  ata_seq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .opcode       (ata_seq_pkg::op_t'(in_tuser)),
    .start_lba    (in_tdata[27:0]),
    .sector_count (in_tdata[43:28]),
    .status_byte  (in_tdata[51:44]),
    .data_word    (in_tdata[67:52]),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .push_job     (push_job),
    .push         (push)
  );

  // jobs waiting for the output side
  ata_seq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // back: burst expansion and output register
  ata_seq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tuser = out_item.action;
  assign out_tlast = out_item.last;
  assign out_tdata = {4'h0, out_item.ok, out_item.word_idx, out_item.sec_idx,
                      out_item.value, out_item.reg_idx};

endmodule

`default_nettype wire
